// ===== design/audio_peak_level_meter_macros.svh =====
// Assertion macros shared by the peak level meter RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef AUDIO_PEAK_LEVEL_METER_MACROS_SVH
`define AUDIO_PEAK_LEVEL_METER_MACROS_SVH

`ifndef SYNTH
// Condition must hold at every clock edge out of reset
`define APLM_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("aplm: invariant violated");
// Consequent must hold in the cycle after the antecedent
`define APLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aplm: next-cycle check failed");
// Consequent must hold in the same cycle as the antecedent
`define APLM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aplm: implication failed");
`else
`define APLM_ASSERT_ALWAYS(lbl, cond)
`define APLM_ASSERT_NEXT(lbl, ante, cons)
`define APLM_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== design/aplm_pkg.sv =====
// Package for the audio peak level meter: widths, constants, config struct,
// magnitude and bar-position functions. No dependencies.
`timescale 1ns / 1ps

package aplm_pkg;

    localparam int SMP_W    = 16;
    localparam int PEAK_W   = 15;
    localparam int CNT_W    = 8;
    localparam int BAR_W    = 4;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [CNT_W-1:0]  PERIOD_RST       = 8'd10;
    localparam logic [PEAK_W-1:0] PEAK_MAX         = 15'h7FFF;
    localparam logic [PEAK_W-1:0] SMALL_PEAK_LIMIT = 15'd250;

    // peak / 1000 as (peak * 33555) >> 25, exact for all 15-bit peaks
    localparam int              RECIP_SHIFT = 25;
    localparam logic [15:0]     RECIP_1000  = 16'd33555;
    localparam int              PROD_W      = PEAK_W + 16;
    localparam int              POS_W       = 6;
    localparam int              BAR_ENTRIES = 33;
    localparam logic [POS_W-1:0] POS_LAST   = 6'd32;

    // Register word index (paddr[2])
    typedef enum logic [0:0] {
        REG_UPDATE_PERIOD = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] update_period;
    } t_cfg;

    localparam logic [BAR_W-1:0] BAR_TABLE [BAR_ENTRIES] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8,
        4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9
    };

    // Absolute value, most negative input saturates to full scale
    function automatic logic [PEAK_W-1:0] magnitude(input logic signed [SMP_W-1:0] smp);
        logic [SMP_W-1:0] neg;
        neg = SMP_W'(-smp);
        if (!smp[SMP_W-1]) begin
            return smp[PEAK_W-1:0];
        end else if (smp == {1'b1, {(SMP_W-1){1'b0}}}) begin
            return PEAK_MAX;
        end else begin
            return neg[PEAK_W-1:0];
        end
    endfunction

    // Bar position from a peak value
    function automatic logic [BAR_W-1:0] bar_of(input logic [PEAK_W-1:0] peak);
        logic [PROD_W-1:0] prod;
        logic [POS_W-1:0]  pos;
        prod = PROD_W'(peak) * PROD_W'(RECIP_1000);
        pos  = prod[RECIP_SHIFT +: POS_W];
        if (pos == '0 && peak > SMALL_PEAK_LIMIT) begin
            pos = POS_W'(1);
        end
        if (pos > POS_LAST) begin
            pos = POS_LAST;
        end
        return BAR_TABLE[pos];
    endfunction

endpackage

// ===== design/aplm_in_if.sv =====
// Sample input channel: valid/ready handshake with sample payload.
// Depends on aplm_pkg for field widths.
`timescale 1ns / 1ps

interface aplm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [aplm_pkg::SMP_W-1:0]   sample;
    logic                                sample_valid;
    logic                                frame_last;

    modport source (output valid, output sample, output sample_valid,
                    output frame_last, input ready);
    modport sink   (input valid, input sample, input sample_valid,
                    input frame_last, output ready);
endinterface

// ===== design/aplm_out_if.sv =====
// Level result channel: valid/ready handshake with meter payload.
// Depends on aplm_pkg for field widths.
`timescale 1ns / 1ps

interface aplm_out_if;
    logic                          valid;
    logic                          ready;
    logic [aplm_pkg::BAR_W-1:0]    bar_level;
    logic [aplm_pkg::PEAK_W-1:0]   full_range_level;
    logic [aplm_pkg::CNT_W-1:0]    frame_count;
    logic                          updated;

    modport source (output valid, output bar_level, output full_range_level,
                    output frame_count, output updated, input ready);
    modport sink   (input valid, input bar_level, input full_range_level,
                    input frame_count, input updated, output ready);
endinterface

// ===== design/aplm_regs.sv =====
// APB configuration register file for the peak level meter (update period).
// Depends on aplm_pkg.
`timescale 1ns / 1ps

module aplm_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aplm_pkg::ADDR_W-1:0]   paddr,
    input  logic [aplm_pkg::DATA_W-1:0]   pwdata,
    output logic [aplm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output aplm_pkg::t_cfg                o_cfg
);

    logic [aplm_pkg::CNT_W-1:0] r_period;
    logic                       w_sel_period;
    logic                       w_wr;

    // word decode, byte offset ignored
    assign w_sel_period = (paddr[2] == aplm_pkg::REG_UPDATE_PERIOD);
    assign w_wr         = psel && penable && pwrite && pready;
    assign pready       = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= aplm_pkg::PERIOD_RST;
        end else if (w_wr && w_sel_period) begin
            r_period <= pwdata[aplm_pkg::CNT_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (w_sel_period) begin
            prdata = aplm_pkg::DATA_W'(r_period);
        end
    end

    assign o_cfg.update_period = r_period;

endmodule

// ===== design/aplm_core.sv =====
// Meter datapath: input register, peak/frame/bar state update, result register.
// Depends on aplm_pkg, aplm_in_if, aplm_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "audio_peak_level_meter_macros.svh"

module aplm_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aplm_pkg::t_cfg  i_cfg,
    aplm_in_if.sink         i_smp,
    aplm_out_if.source      o_lvl
);

    // input register
    logic                                r_in_vld;
    logic signed [aplm_pkg::SMP_W-1:0]   r_sample;
    logic                                r_smp_vld;
    logic                                r_last;

    // meter state
    logic [aplm_pkg::PEAK_W-1:0] r_peak, n_peak;
    logic [aplm_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [aplm_pkg::BAR_W-1:0]  r_bar, n_bar;
    logic [aplm_pkg::PEAK_W-1:0] r_pub, n_pub;

    // result register
    logic                        r_out_vld;
    logic [aplm_pkg::BAR_W-1:0]  r_out_bar;
    logic [aplm_pkg::PEAK_W-1:0] r_out_full;
    logic [aplm_pkg::CNT_W-1:0]  r_out_cnt;
    logic                        r_out_upd;
    logic                        n_upd;

    logic                        w_out_free;
    logic                        w_adv;
    logic                        w_in_fire;
    logic                        w_hit;
    logic [aplm_pkg::PEAK_W-1:0] w_mag;
    logic [aplm_pkg::PEAK_W-1:0] w_peak_new;

    // handshake: result slot free, stage advance, input accept
    assign w_out_free  = !r_out_vld || o_lvl.ready;
    assign w_adv       = r_in_vld && w_out_free;
    assign i_smp.ready = !r_in_vld || w_out_free;
    assign w_in_fire   = i_smp.valid && i_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_vld <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_sample  <= i_smp.sample;
            r_smp_vld <= i_smp.sample_valid;
            r_last    <= i_smp.frame_last;
        end
    end

    // peak merge, frame counter check, publish and decay
    always_comb begin
        w_mag      = aplm_pkg::magnitude(r_sample);
        w_peak_new = r_peak;
        if (r_smp_vld && w_mag > r_peak) begin
            w_peak_new = w_mag;
        end
        w_hit = r_last && (r_cnt == i_cfg.update_period);

        n_peak = w_peak_new;
        n_cnt  = r_cnt;
        n_bar  = r_bar;
        n_pub  = r_pub;
        n_upd  = 1'b0;
        if (w_hit) begin
            n_cnt  = '0;
            n_pub  = w_peak_new;
            n_bar  = aplm_pkg::bar_of(w_peak_new);
            n_peak = w_peak_new >> 2;
            n_upd  = 1'b1;
        end else if (r_last) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_cnt  <= '0;
            r_bar  <= '0;
            r_pub  <= '0;
        end else if (w_adv) begin
            r_peak <= n_peak;
            r_cnt  <= n_cnt;
            r_bar  <= n_bar;
            r_pub  <= n_pub;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_bar  <= n_bar;
            r_out_full <= n_pub;
            r_out_cnt  <= n_cnt;
            r_out_upd  <= n_upd;
        end
    end

    assign o_lvl.valid            = r_out_vld;
    assign o_lvl.bar_level        = r_out_bar;
    assign o_lvl.full_range_level = r_out_full;
    assign o_lvl.frame_count      = r_out_cnt;
    assign o_lvl.updated          = r_out_upd;

    // checks
    `APLM_ASSERT_IMPL(a_upd_clears_cnt, r_out_vld && r_out_upd, r_out_cnt == '0)
    `APLM_ASSERT_NEXT(a_decay, w_adv && w_hit, r_peak == (r_pub >> 2))
    `APLM_ASSERT_IMPL(a_zero_bar_small, r_out_vld && r_out_bar == '0,
                      r_out_full <= aplm_pkg::SMALL_PEAK_LIMIT)
    `APLM_ASSERT_NEXT(a_result_held, r_out_vld && !o_lvl.ready,
                      r_out_vld && $stable(r_out_full))
    `APLM_ASSERT_ALWAYS(a_bar_range, r_bar <= 4'd9)

endmodule

// ===== design/audio_peak_level_meter.sv =====
// Audio peak level meter: an accepted sample passes the input register, then the result
// register. Throughput one word per cycle while o_lvl.ready holds; the two registers
// decouple the two sides, and the peak/counter update is combinational between them.
// Synchronous active-low reset clears peak, counter, bar and published level,
// and loads update period 10.
// Depends on aplm_pkg, aplm_in_if, aplm_out_if, aplm_regs and aplm_core.
`timescale 1ns / 1ps

module audio_peak_level_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    aplm_in_if.sink                       i_smp,
    aplm_out_if.source                    o_lvl,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aplm_pkg::ADDR_W-1:0]   paddr,
    input  logic [aplm_pkg::DATA_W-1:0]   pwdata,
    output logic [aplm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    aplm_pkg::t_cfg w_cfg;

    // configuration registers
    aplm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // meter datapath
    aplm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_smp   (i_smp),
        .o_lvl   (o_lvl)
    );

endmodule
